// ----- sv/lowest_free_id_allocator_macros.svh -----
// Assertion macros used by the id allocator RTL.
// Depends on a clk and an arst_n signal in the including module.
`ifndef LOWEST_FREE_ID_ALLOCATOR_MACROS_SVH
`define LOWEST_FREE_ID_ALLOCATOR_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define LFA_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define LFA_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- sv/lfa_pkg.sv -----
// Types and constants of the lowest free id allocator.
// No dependencies; used by lfa_map and lowest_free_id_allocator.
`default_nettype none

package lfa_pkg;

	localparam int WORD_W = 16;
	localparam int ADDR_W = 4;
	localparam int MAP_WORDS = 16;
	localparam int MARK_W = 9;

	// Request opcodes
	localparam logic OP_ALLOC = 1'b0;
	localparam logic OP_FREE  = 1'b1;

	// Result status codes
	localparam logic [1:0] STAT_OK        = 2'd0;
	localparam logic [1:0] STAT_NO_FREE   = 2'd1;
	localparam logic [1:0] STAT_INVALID   = 2'd2;
	localparam logic [1:0] STAT_NOT_ALLOC = 2'd3;

	// Access to the used map: one read and one write port
	typedef struct packed {
		logic              rd_en;
		logic [ADDR_W-1:0] rd_addr;
		logic              wr_en;
		logic [ADDR_W-1:0] wr_addr;
		logic [WORD_W-1:0] wr_data;
	} map_req_t;

endpackage

`default_nettype wire

// ----- sv/lfa_map.sv -----
// Used map of the id allocator: 16 words of 16 bits, registered read port.
// Depends on lfa_pkg. Row valid bits make every word read as zero after reset.
`default_nettype none

module lfa_map (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire lfa_pkg::map_req_t           req,
	output logic [lfa_pkg::WORD_W-1:0]       rdata
);
	import lfa_pkg::*;

	logic [WORD_W-1:0]    mem [MAP_WORDS];
	logic [MAP_WORDS-1:0] row_vld_q;
	logic [WORD_W-1:0]    raw_s1;
	logic                 rvld_s1;

	// Write port
	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			mem[req.wr_addr] <= req.wr_data;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		if (req.rd_en) begin
			raw_s1 <= mem[req.rd_addr];
		end
	end

	// Track written rows; capture row validity with the read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_vld_q <= '0;
			rvld_s1   <= 1'b0;
		end else begin
			if (req.wr_en) begin
				row_vld_q[req.wr_addr] <= 1'b1;
			end
			if (req.rd_en) begin
				rvld_s1 <= row_vld_q[req.rd_addr];
			end
		end
	end

	// Unwritten rows read as all free
	assign rdata = rvld_s1 ? raw_s1 : '0;

endmodule

`default_nettype wire

// ----- sv/lowest_free_id_allocator.sv -----
// Top level of the lowest free id allocator.
// Depends on lfa_pkg, lfa_map and lowest_free_id_allocator_macros.svh.
//
// Usage:
//   A request is taken when start is high and busy is low. opcode 0 allocates
//   the lowest free id below the high-water mark, or the mark itself (raising
//   it) when none is free. opcode 1 frees the id on pid.
//   Each request yields one result: done pulses for one cycle with status and
//   granted_id. The receiver cannot stall; results are never held back.
// Sequence:
//   Free of an out-of-range id: result in the cycle after acceptance.
//   Free of a valid id: map read, then write back, then the result.
//   Allocate: N = ceil(mark / 16) words of the used map are read one per
//   cycle, stopping early at the first word with a free id. busy is high
//   while a request uses the map; an out-of-range free leaves it low. The
//   next request is taken at the earliest in the cycle that done is high.
// Reset:
//   arst_n clears the mark and all map row valid bits, so every id is free at
//   once; no clearing pass is needed.
`default_nettype none

module lowest_free_id_allocator #(
	parameter int ID_LIMIT = 255
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire logic        opcode,
	input  wire logic [15:0] pid,
	output logic             done,
	output logic [1:0]       status,
	output logic [7:0]       granted_id
);
	import lfa_pkg::*;

	`include "lowest_free_id_allocator_macros.svh"

	localparam int EFF_LIMIT = (ID_LIMIT > 255) ? 255 : ID_LIMIT;
	localparam logic [MARK_W-1:0] LIM_MARK = MARK_W'(EFF_LIMIT);
	localparam logic [15:0]       LIM_PID  = 16'(EFF_LIMIT);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_SCAN = 2'd1;
	localparam logic [1:0] S_FREE = 2'd2;

	logic [1:0]        state_q, state_d;
	logic [MARK_W-1:0] mark_q;
	logic [4:0]        rd_idx_q;
	logic              rvld_s1;
	logic [ADDR_W-1:0] ridx_s1;
	logic [3:0]        pbit_q;
	logic [ADDR_W-1:0] pword_q;
	logic              done_q;
	logic [1:0]        status_q;
	logic [7:0]        granted_q;

	map_req_t          req;
	logic [WORD_W-1:0] rdata;

	logic [9:0]        mark_rnd;
	logic [4:0]        nwords;
	logic              rd_issue;
	logic              free_bad;
	logic [WORD_W-1:0] idmask, free_bits, low_bit, append_base, append_bit, pid_bit;
	logic [3:0]        low_enc;
	logic              found, last_word;
	logic              fin, mark_inc;
	logic [1:0]        fin_status;
	logic [7:0]        fin_grant;

	lfa_map u_map (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req),
		.rdata (rdata)
	);

	// Number of map words holding ids below the mark
	assign mark_rnd = {1'b0, mark_q} + 10'd15;
	assign nwords   = mark_rnd[8:4];
	assign rd_issue = (state_q == S_SCAN) && (rd_idx_q < nwords);

	// Reject ids that were never handed out or can never be freed
	assign free_bad = (pid == 16'd0) || (pid > LIM_PID) || ({7'd0, mark_q} <= pid);

	// Find the lowest free id in the returned word
	always_comb begin
		if ({1'b0, ridx_s1} < mark_q[8:4]) begin
			idmask = '1;
		end else begin
			idmask = (16'd1 << mark_q[3:0]) - 16'd1;
		end
		free_bits = ~rdata & idmask;
		low_bit   = free_bits & (~free_bits + 16'd1);
		found     = |free_bits;
		low_enc   = '0;
		for (int b = 0; b < WORD_W; b++) begin
			if (low_bit[b]) begin
				low_enc = low_enc | 4'(b);
			end
		end
		last_word   = ({1'b0, ridx_s1} == (nwords - 5'd1));
		append_base = ((nwords == 5'd0) || (mark_q[3:0] == 4'd0)) ? '0 : rdata;
		append_bit  = 16'd1 << mark_q[3:0];
		pid_bit     = 16'd1 << pbit_q;
	end

	// Sequence a request: map access, result and next state
	always_comb begin
		req        = '0;
		fin        = 1'b0;
		fin_status = STAT_OK;
		fin_grant  = '0;
		mark_inc   = 1'b0;
		state_d    = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					if (opcode == OP_ALLOC) begin
						state_d = S_SCAN;
					end else if (free_bad) begin
						fin        = 1'b1;
						fin_status = STAT_INVALID;
					end else begin
						req.rd_en   = 1'b1;
						req.rd_addr = pid[7:4];
						state_d     = S_FREE;
					end
				end
			end
			S_SCAN: begin
				req.rd_en   = rd_issue;
				req.rd_addr = rd_idx_q[3:0];
				if (rvld_s1 && found) begin
					req.wr_en   = 1'b1;
					req.wr_addr = ridx_s1;
					req.wr_data = rdata | low_bit;
					fin         = 1'b1;
					fin_grant   = {ridx_s1, low_enc};
					state_d     = S_IDLE;
				end else if ((rvld_s1 && last_word) || (nwords == 5'd0)) begin
					fin     = 1'b1;
					state_d = S_IDLE;
					if (mark_q > LIM_MARK) begin
						fin_status = STAT_NO_FREE;
					end else begin
						req.wr_en   = 1'b1;
						req.wr_addr = mark_q[7:4];
						req.wr_data = append_base | append_bit;
						fin_grant   = mark_q[7:0];
						mark_inc    = 1'b1;
					end
				end
			end
			S_FREE: begin
				fin     = 1'b1;
				state_d = S_IDLE;
				if (|(rdata & pid_bit)) begin
					req.wr_en   = 1'b1;
					req.wr_addr = pword_q;
					req.wr_data = rdata & ~pid_bit;
				end else begin
					fin_status = STAT_NOT_ALLOC;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// Control state, mark and result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			mark_q   <= '0;
			rd_idx_q <= '0;
			rvld_s1  <= 1'b0;
			done_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= fin;
			if (mark_inc) begin
				mark_q <= mark_q + 9'd1;
			end
			if (state_q == S_IDLE) begin
				rd_idx_q <= '0;
				rvld_s1  <= 1'b0;
			end else begin
				rd_idx_q <= rd_idx_q + {4'd0, rd_issue};
				rvld_s1  <= rd_issue;
			end
		end
	end

	// Payload registers: scan index, free target, result fields
	always_ff @(posedge clk) begin
		ridx_s1 <= rd_idx_q[3:0];
		if ((state_q == S_IDLE) && start) begin
			pbit_q  <= pid[3:0];
			pword_q <= pid[7:4];
		end
		if (fin) begin
			status_q  <= fin_status;
			granted_q <= fin_grant;
		end
	end

	assign busy       = (state_q != S_IDLE);
	assign done       = done_q;
	assign status     = status_q;
	assign granted_id = granted_q;

	`LFA_ASSERT_NEXT(a_mark_monotonic, 1'b1, mark_q >= $past(mark_q), "mark decreased")
	`LFA_ASSERT_NOW(a_mark_bound, 1'b1, mark_q <= LIM_MARK + 9'd1, "mark beyond limit")
	`LFA_ASSERT_NOW(a_done_idle, done_q, state_q == S_IDLE, "result while busy")
	`LFA_ASSERT_NOW(a_grant_ok, done_q && (granted_q != 8'd0), status_q == STAT_OK,
		"nonzero grant with error status")
	`LFA_ASSERT_NOW(a_write_busy, req.wr_en, state_q != S_IDLE, "map write while idle")

endmodule

`default_nettype wire

// ----- tb/lfa_checker.sv -----
// Checker for the lowest free id allocator: predicts every result and compares it.
// Watches the request and result ports beside the block; depends on lfa_pkg.
module lfa_checker #(
	parameter int ID_LIMIT = 255
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic        busy,
	input  logic        opcode,
	input  logic [15:0] pid,
	input  logic        done,
	input  logic [1:0]  status,
	input  logic [7:0]  granted_id,
	output int          mismatches,
	output int          pending
);
	timeunit 1ns;
	timeprecision 1ps;
	import lfa_pkg::*;

	localparam int ID_SLOTS = 256;
	// The map holds 256 ids, so the usable limit is capped at 255
	localparam int TOP_ID = (ID_LIMIT > ID_SLOTS - 1) ? ID_SLOTS - 1 : ID_LIMIT;

	typedef struct packed {
		logic [1:0] status;
		logic [7:0] granted_id;
	} grant_t;

	grant_t            expected_grants[$];
	bit                id_taken[ID_SLOTS];
	logic [MARK_W-1:0] mark;

	task automatic report_mismatch(input string what, input int want, input int got);
		$display("[%0t] id allocator %s: expected %0d, got %0d", $time, what, want, got);
		mismatches++;
	endtask

	// Apply one request to the shadow map and return the result it must give
	function automatic grant_t apply_request(input logic op, input logic [15:0] id);
		grant_t g;
		bit     found;
		int     slot;
		int     i;
		g.status = STAT_OK;
		g.granted_id = '0;
		found = 1'b0;
		slot = 0;
		if (op == OP_ALLOC) begin
			for (i = 0; i < int'(mark); i++) begin
				if (!found && !id_taken[i]) begin
					found = 1'b1;
					slot = i;
				end
			end
			if (found) begin
				id_taken[slot] = 1'b1;
				g.granted_id = slot[7:0];
			end else if (int'(mark) > TOP_ID) begin
				g.status = STAT_NO_FREE;
			end else begin
				id_taken[mark[7:0]] = 1'b1;
				g.granted_id = mark[7:0];
				mark = mark + MARK_W'(1);
			end
		end else begin
			if (id == 16'd0 || int'(id) > TOP_ID || int'(id) >= int'(mark)) begin
				g.status = STAT_INVALID;
			end else if (!id_taken[id[7:0]]) begin
				g.status = STAT_NOT_ALLOC;
			end else begin
				id_taken[id[7:0]] = 1'b0;
			end
		end
		return g;
	endfunction

	// Retire results first, then predict the request taken at the same edge
	always @(posedge clk or negedge arst_n) begin
		grant_t want;
		if (!arst_n) begin
			expected_grants.delete();
			foreach (id_taken[k]) id_taken[k] = 1'b0;
			mark = '0;
			mismatches = 0;
			pending <= 0;
		end else begin
			if (done) begin
				if (expected_grants.size() == 0) begin
					report_mismatch("result with no request waiting, status", -1, status);
				end else begin
					want = expected_grants.pop_front();
					if (status !== want.status)
						report_mismatch("status", want.status, status);
					if (granted_id !== want.granted_id)
						report_mismatch("granted_id", want.granted_id, granted_id);
				end
			end
			if (start && !busy)
				expected_grants.push_back(apply_request(opcode, pid));
			pending <= expected_grants.size();
		end
	end

endmodule

// ----- tb/tb_lowest_free_id_allocator.sv -----
// Testbench top for the lowest free id allocator: clock, reset, requests, verdict.
// Depends on lfa_pkg, the allocator RTL and lfa_checker.
module tb_lowest_free_id_allocator;
	timeunit 1ns;
	timeprecision 1ps;
	import lfa_pkg::*;

	localparam int CYCLE_LIMIT = 400000;
	localparam int PHASES = 4;

	logic        clk;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic        opcode = OP_ALLOC;
	logic [15:0] pid = 16'd0;
	logic        busy;
	logic        done;
	logic [1:0]  status;
	logic [7:0]  granted_id;
	int          mismatches;
	int          pending;
	int          cycles = 0;
	int          gap_pct = 0;

	// Per phase: request count, share of allocates, sender idle share
	int phase_count[PHASES] = '{200, 200, 200, 150};
	int phase_alloc[PHASES] = '{75, 95, 35, 60};
	int phase_gap[PHASES]   = '{0, 82, 0, 38};

	lowest_free_id_allocator #(.ID_LIMIT(255)) dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.opcode     (opcode),
		.pid        (pid),
		.done       (done),
		.status     (status),
		.granted_id (granted_id)
	);

	lfa_checker #(.ID_LIMIT(255)) u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.opcode     (opcode),
		.pid        (pid),
		.done       (done),
		.status     (status),
		.granted_id (granted_id),
		.mismatches (mismatches),
		.pending    (pending)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Abort a hung run
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("end of test: mismatches");
			$finish;
		end
	end

	// Hold the request until the block takes it, idling first at random
	task automatic issue(input logic op, input logic [15:0] id);
		while ($urandom_range(99) < gap_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		opcode <= op;
		pid <= id;
		do @(posedge clk); while (busy);
	endtask

	// Drop start and wait until every result has come back
	task automatic drain();
		start <= 1'b0;
		do @(posedge clk); while (pending != 0);
	endtask

	// Pick a free target: mostly low ids that are likely held, some out of range
	function automatic logic [15:0] free_target();
		int r;
		r = $urandom_range(99);
		if (r < 60)
			return 16'($urandom_range(1, 63));
		else if (r < 85)
			return 16'($urandom_range(1, 255));
		else if (r < 93)
			return 16'($urandom_range(256, 65535));
		else if (r < 96)
			return 16'd0;
		else
			return 16'($urandom);
	endfunction

	initial begin
		int p;
		int n;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: first grant, out-of-range frees, reuse of the lowest hole
		issue(OP_ALLOC, 16'd0);
		issue(OP_FREE, 16'd0);
		issue(OP_FREE, 16'd1);
		issue(OP_FREE, 16'hFFFF);
		issue(OP_FREE, 16'd256);
		issue(OP_ALLOC, 16'hFFFF);
		issue(OP_ALLOC, 16'h5555);
		issue(OP_ALLOC, 16'hAAAA);
		issue(OP_FREE, 16'd2);
		issue(OP_FREE, 16'd2);
		issue(OP_ALLOC, 16'hFFFF);
		issue(OP_FREE, 16'd4);
		issue(OP_FREE, 16'd255);
		issue(OP_FREE, 16'd3);
		issue(OP_FREE, 16'd1);
		issue(OP_ALLOC, 16'd0);
		issue(OP_ALLOC, 16'd0);
		issue(OP_ALLOC, 16'd0);
		issue(OP_FREE, 16'h8001);
		issue(OP_FREE, 16'h5555);
		issue(OP_FREE, 16'hAAAA);
		issue(OP_FREE, 16'd4);
		issue(OP_FREE, 16'd4);
		drain();

		// Random: grow the table, exhaust it, thin it out, then mix
		for (p = 0; p < PHASES; p++) begin
			gap_pct = phase_gap[p];
			for (n = 0; n < phase_count[p]; n++) begin
				if ($urandom_range(99) < phase_alloc[p])
					issue(OP_ALLOC, 16'($urandom));
				else
					issue(OP_FREE, free_target());
			end
			drain();
		end

		repeat (40) @(posedge clk);
		if (mismatches == 0 && pending == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule

// ----- filelist.f -----
+incdir+sv
sv/lfa_pkg.sv
sv/lfa_map.sv
sv/lowest_free_id_allocator.sv
tb/lfa_checker.sv
tb/tb_lowest_free_id_allocator.sv
